// ===== rtl/core/mdf_pkg.sv =====
// Types and constants shared by the mipmap downsample filter modules.
`default_nettype none
package mdf_pkg;

  // One RGB pixel as it travels on the source channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One filtered pixel on the result channel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } out_pix_t;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [1:0] CFG_SRC_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_SRC_HEIGHT  = 2'd2;

  localparam int CFG_DATA_W = 13;

  // Tent weights: centre 4, ring 1, normalized by 28.
  // x/28 for x < 7141 equals (x * 9363) >> 18.
  localparam int          TENT_SUM_W  = 13;
  localparam logic [13:0] TENT_RECIP  = 14'd9363;
  localparam int          TENT_SHIFT  = 18;

  localparam int QDEPTH = 4;

  // One source column of the 4x4 window plus what the back end must do with it.
  // col[3] is the current row, col[0] three rows up.
  typedef struct packed {
    pix_t [3:0] col;
    logic       emit;
    logic       tent;
    logic       last_row;
    logic       last_col;
    logic       frame_last;
  } col_beat_t;

endpackage
`default_nettype wire

// ===== rtl/core/mdf_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module mdf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mdf_front.sv =====
// Front end: configuration, raster position, classification and line store.
`default_nettype none
module mdf_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            src_valid,
  output      logic                            src_stall,
  input  wire mdf_pkg::pix_t                   src_pixel,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [mdf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [$clog2(mdf_pkg::QDEPTH):0] q_count,
  output      logic                            push,
  output      mdf_pkg::col_beat_t              push_beat
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = CW + 1;
  localparam int WCAP = (MAX_WIDTH / 2) * 2;
  localparam int WRST = (WCAP < 2048) ? WCAP : 2048;

  logic          mode;
  logic [EW-1:0] eff_w;
  logic [12:0]   eff_h;
  logic [CW-1:0] col;
  logic [12:0]   row;

  logic          accept;
  logic          s1_valid;
  mdf_pkg::pix_t s1_pix;
  logic [1:0]    s1_slot;
  logic          s1_emit, s1_tent, s1_last_row, s1_last_col, s1_last;

  logic [13:0]   w_req, w_sel;
  logic [12:0]   h_req, h_sel;
  logic          cfg_hit;

  logic [EW-1:0] col_x;
  logic          last_row, last_col, row_hit, col_hit, tent_row, tent_col;

  logic [23:0]   rdata [4];
  logic [1:0]    slot;

  assign cfg_ready = 1'b1;
  assign accept    = src_valid && !src_stall;
  assign src_stall = ({1'b0, q_count} + {{($clog2(mdf_pkg::QDEPTH)+1){1'b0}}, s1_valid})
                     >= ($clog2(mdf_pkg::QDEPTH)+2)'(mdf_pkg::QDEPTH);

  // Clamp the requested dimensions: even, at least 2, width capped.
  always_comb begin
    w_req = {1'b0, 1'b0, cfg_wdata[11:1], 1'b0};
    if (w_req < 14'd2) begin
      w_sel = 14'd2;
    end else if (w_req > 14'(WCAP)) begin
      w_sel = 14'(WCAP);
    end else begin
      w_sel = w_req;
    end
    h_req = {cfg_wdata[12:1], 1'b0};
    h_sel = (h_req < 13'd2) ? 13'd2 : h_req;
    cfg_hit = cfg_valid && cfg_ready &&
              (cfg_index == mdf_pkg::CFG_FILTER_MODE ||
               cfg_index == mdf_pkg::CFG_SRC_WIDTH ||
               cfg_index == mdf_pkg::CFG_SRC_HEIGHT);
  end

  // Which output (if any) this pixel completes, and how it is filtered.
  always_comb begin
    col_x    = {1'b0, col};
    last_row = (row == eff_h - 13'd1);
    last_col = (col_x == eff_w - EW'(1));
    row_hit  = last_row || (!row[0] && row >= 13'd2);
    col_hit  = last_col || (!col[0] && col_x >= EW'(2));
    tent_row = !row[0] && !last_row && row >= 13'd6 &&
               ({1'b0, row} + 14'd4) <= {1'b0, eff_h};
    tent_col = !col[0] && !last_col && col_x >= EW'(6) &&
               (col_x + EW'(4)) <= eff_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      eff_w    <= EW'(WRST);
      eff_h    <= 13'd2048;
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (cfg_hit) begin
        case (cfg_index)
          mdf_pkg::CFG_FILTER_MODE: mode  <= cfg_wdata[0];
          mdf_pkg::CFG_SRC_WIDTH:   eff_w <= w_sel[EW-1:0];
          mdf_pkg::CFG_SRC_HEIGHT:  eff_h <= h_sel;
          default: ;
        endcase
        col <= '0;
        row <= '0;
      end else if (accept) begin
        if (col_x + EW'(1) >= eff_w) begin
          col <= '0;
          row <= ({1'b0, row} + 14'd1 >= {1'b0, eff_h}) ? 13'd0 : row + 13'd1;
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= src_pixel;
      s1_slot     <= row[1:0];
      s1_emit     <= row_hit && col_hit;
      s1_tent     <= mode && tent_row && tent_col;
      s1_last_row <= last_row;
      s1_last_col <= last_col;
      s1_last     <= last_row && last_col;
    end
  end

  // Four line slots, row modulo 4; all read at the current column.
  for (genvar g = 0; g < 4; g++) begin : g_line
    mdf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line (
      .clk   (clk),
      .we    (accept && row[1:0] == 2'(g)),
      .waddr (col),
      .wdata (src_pixel),
      .raddr (col),
      .rdata (rdata[g])
    );
  end

  always_comb begin
    push_beat.col[3] = s1_pix;
    for (int k = 1; k < 4; k++) begin
      slot = s1_slot - 2'(k);
      push_beat.col[3-k] = rdata[slot];
    end
    push_beat.emit       = s1_emit;
    push_beat.tent       = s1_tent;
    push_beat.last_row   = s1_last_row;
    push_beat.last_col   = s1_last_col;
    push_beat.frame_last = s1_last;
  end

  assign push = s1_valid;

endmodule
`default_nettype wire

// ===== rtl/core/mdf_queue.sv =====
// Short queue of column beats between the front and back ends.
`default_nettype none
module mdf_queue (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  input  wire mdf_pkg::col_beat_t               push_beat,
  input  wire logic                             pop,
  output      mdf_pkg::col_beat_t               head,
  output      logic                             not_empty,
  output      logic [$clog2(mdf_pkg::QDEPTH):0] count
);

  localparam int AW = $clog2(mdf_pkg::QDEPTH);

  mdf_pkg::col_beat_t slots [mdf_pkg::QDEPTH];
  logic [AW-1:0]      wr_ptr, rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mdf_back.sv =====
// Back end: 4x4 window, box and tent sums, normalize, output register.
`default_nettype none
module mdf_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_not_empty,
  input  wire mdf_pkg::col_beat_t q_head,
  output      logic               pop,
  output      logic               dst_valid,
  input  wire logic               dst_stall,
  output      mdf_pkg::out_pix_t  dst_pixel
);

  // win[c][r]: c = 3 newest column, r = 3 current row.
  mdf_pkg::pix_t [3:0][3:0] win;
  logic          adv;
  logic          a_valid, a_tent, a_last_row, a_last_col, a_last;
  logic          b_valid, b_tent, b_last;
  logic [mdf_pkg::TENT_SUM_W-1:0] b_tent_sum [3];
  logic [7:0]    b_box [3];

  logic [9:0]    centre [3];
  logic [11:0]   ring [3];
  logic [9:0]    box [3];
  logic [1:0]    rs, cs;
  logic [7:0]    q [3];
  logic [27:0]   prod;

  function automatic logic [7:0] chan_of(mdf_pkg::pix_t p, int k);
    logic [7:0] v;
    case (k)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  assign adv = !(dst_valid && dst_stall);
  assign pop = adv && q_not_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      win[2:0] <= win[3:1];
      win[3]   <= q_head.col;
    end
    if (adv) begin
      a_tent     <= q_head.tent;
      a_last_row <= q_head.last_row;
      a_last_col <= q_head.last_col;
      a_last     <= q_head.frame_last;
    end
  end

  always_comb begin
    rs = a_last_row ? 2'd2 : 2'd1;
    cs = a_last_col ? 2'd2 : 2'd1;
    for (int ch = 0; ch < 3; ch++) begin
      centre[ch] = 10'(chan_of(win[1][1], ch)) + 10'(chan_of(win[2][1], ch)) +
                   10'(chan_of(win[1][2], ch)) + 10'(chan_of(win[2][2], ch));
      ring[ch] = '0;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          if (!((c == 1 || c == 2) && (r == 1 || r == 2))) begin
            ring[ch] = ring[ch] + 12'(chan_of(win[c][r], ch));
          end
        end
      end
      box[ch] = 10'(chan_of(win[cs][rs], ch)) + 10'(chan_of(win[cs+2'd1][rs], ch)) +
                10'(chan_of(win[cs][rs+2'd1], ch)) +
                10'(chan_of(win[cs+2'd1][rs+2'd1], ch));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tent <= a_tent;
      b_last <= a_last;
      for (int ch = 0; ch < 3; ch++) begin
        b_tent_sum[ch] <= {1'b0, centre[ch], 2'b00} + 13'(ring[ch]);
        b_box[ch]      <= box[ch][9:2];
      end
    end
  end

  // Divide by 28 through the reciprocal.
  always_comb begin
    prod = '0;
    for (int ch = 0; ch < 3; ch++) begin
      prod  = 28'({1'b0, b_tent_sum[ch]} * 28'(mdf_pkg::TENT_RECIP));
      q[ch] = b_tent ? prod[mdf_pkg::TENT_SHIFT +: 8] : b_box[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      dst_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= pop && q_head.emit;
      b_valid   <= a_valid;
      dst_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst_pixel.out_red    <= q[0];
      dst_pixel.out_green  <= q[1];
      dst_pixel.out_blue   <= q[2];
      dst_pixel.frame_last <= b_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mipmap_downsample_filter.sv =====
// Top level of the half-size mipmap level generator.
//
// Source beats (src_valid/src_stall/src_pixel) carry RGB pixels in raster
// order; a beat moves on an edge with src_valid high and src_stall low.
// Result beats (dst_valid/dst_stall/dst_pixel) carry the filtered half-size
// pixels in raster order, frame_last set on the final one of a level.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_wdata): index 0 filter
// mode (0 box, 1 tent inside borders), 1 source width, 2 source height.
// Any write to a known index restarts the frame at pixel (0,0); write only
// while idle. cfg_ready is always high.
//
// Throughput: one source pixel per cycle while src_stall is low, set by
// the single write/read port pair of each line RAM. The result a pixel
// completes passes the line RAM read stage, the queue, the window shift
// at pop, the sums register and the normalize/output register on its way
// to dst_valid. When dst_stall holds a valid result, the back end freezes;
// src_stall rises once the queued beats plus the one in the line RAM stage
// reach the four entries. No beat is dropped.
// Reset (rst, synchronous): box mode, 2048x2048, position (0,0), queue
// empty. Line RAMs are not cleared; every pixel a result uses is of this frame.
`default_nettype none
module mipmap_downsample_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           src_valid,
  output      logic                           src_stall,
  input  wire mdf_pkg::pix_t                  src_pixel,
  output      logic                           dst_valid,
  input  wire logic                           dst_stall,
  output      mdf_pkg::out_pix_t              dst_pixel,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [mdf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                             push, pop, q_not_empty;
  mdf_pkg::col_beat_t               push_beat, q_head;
  logic [$clog2(mdf_pkg::QDEPTH):0] q_count;

  // Front: position tracking, classification, line store reads.
  mdf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_pixel (src_pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .push      (push),
    .push_beat (push_beat)
  );

  // Decoupling queue; front stalls before it can overflow.
  mdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  // Back: window shift, filter arithmetic, output register.
  mdf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .dst_valid   (dst_valid),
    .dst_stall   (dst_stall),
    .dst_pixel   (dst_pixel)
  );

endmodule
`default_nettype wire

// ===== sim/mipmap_downsample_filter_checker.sv =====
// Checker for the mipmap downsample filter: predicts each half-size pixel and compares.
`default_nettype none
module mipmap_downsample_filter_checker #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           src_valid,
  input  wire logic                           src_stall,
  input  wire mdf_pkg::pix_t                  src_pixel,
  input  wire logic                           dst_valid,
  input  wire logic                           dst_stall,
  input  wire mdf_pkg::out_pix_t              dst_pixel,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [mdf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                  fail_count,
  output int                                  pending
);
  import mdf_pkg::*;

  localparam int WCAP = (MAX_WIDTH / 2) * 2;

  pix_t     lines [4][MAX_WIDTH];
  logic     tent_mode;
  int       width_reg, height_reg;
  int       frame_w, frame_h, col_pos, row_pos;
  out_pix_t expected_pixels[$];

  assign pending = expected_pixels.size();

  initial begin
    fail_count = 0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < MAX_WIDTH; c++) lines[r][c] = '0;
  end

  // clamp dimensions and restart the frame
  function automatic void restart_frame();
    int w, h;
    w = width_reg & ~1;
    h = height_reg & ~1;
    if (w < 2) w = 2;
    if (w > WCAP) w = WCAP;
    if (h < 2) h = 2;
    frame_w = w;
    frame_h = h;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int sample_chan(int r, int c, int ch);
    pix_t p;
    if (c >= MAX_WIDTH) return 0;
    p = lines[r & 3][c];
    case (ch)
      0:       return p.red;
      1:       return p.green;
      default: return p.blue;
    endcase
  endfunction

  function automatic logic [7:0] downsample_chan(int i, int j, int ch, bit tent);
    int r, c, centre, ring;
    r = 2 * i;
    c = 2 * j;
    centre = sample_chan(r, c, ch) + sample_chan(r, c + 1, ch)
           + sample_chan(r + 1, c, ch) + sample_chan(r + 1, c + 1, ch);
    if (!tent) return 8'(centre / 4);
    ring = 0;
    for (int k = 0; k < 4; k++) begin
      ring += sample_chan(r - 1, c - 1 + k, ch);
      ring += sample_chan(r + 2, c - 1 + k, ch);
    end
    ring += sample_chan(r, c - 1, ch) + sample_chan(r, c + 2, ch);
    ring += sample_chan(r + 1, c - 1, ch) + sample_chan(r + 1, c + 2, ch);
    return 8'((4 * centre + ring) / 28);
  endfunction

  // take one source pixel; queue the result it completes, if any
  function automatic void take_pixel(pix_t p);
    int r, c, ho, wo, i, j;
    bit row_hit, col_hit, tent;
    out_pix_t o;
    r = row_pos;
    c = col_pos;
    ho = frame_h / 2;
    wo = frame_w / 2;
    i = 0; j = 0; row_hit = 0; col_hit = 0;
    if (c < MAX_WIDTH) lines[r & 3][c] = p;
    if (r == frame_h - 1) begin
      row_hit = 1; i = ho - 1;
    end else if (r % 2 == 0 && r >= 2) begin
      row_hit = 1; i = r / 2 - 1;
    end
    if (c == frame_w - 1) begin
      col_hit = 1; j = wo - 1;
    end else if (c % 2 == 0 && c >= 2) begin
      col_hit = 1; j = c / 2 - 1;
    end
    if (row_hit && col_hit) begin
      tent = tent_mode && i >= 2 && i + 3 <= ho && j >= 2 && j + 3 <= wo;
      o.out_red    = downsample_chan(i, j, 0, tent);
      o.out_green  = downsample_chan(i, j, 1, tent);
      o.out_blue   = downsample_chan(i, j, 2, tent);
      o.frame_last = (i == ho - 1 && j == wo - 1);
      expected_pixels = {expected_pixels, o};
    end
    col_pos = c + 1;
    if (col_pos >= frame_w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= frame_h) row_pos = 0;
    end
  endfunction

  always @(posedge clk) begin
    out_pix_t want;
    if (rst) begin
      tent_mode = 0;
      width_reg = 2048;
      height_reg = 2048;
      restart_frame();
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FILTER_MODE: begin tent_mode = cfg_wdata[0]; restart_frame(); end
          CFG_SRC_WIDTH:   begin width_reg = cfg_wdata[11:0]; restart_frame(); end
          CFG_SRC_HEIGHT:  begin height_reg = cfg_wdata[12:0]; restart_frame(); end
          default: ;
        endcase
      end
      if (src_valid && !src_stall) take_pixel(src_pixel);
      if (dst_valid && !dst_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result beat got %h", $time, dst_pixel);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.out_red !== dst_pixel.out_red) begin
            $display("%0t: out_red expected %h got %h", $time, want.out_red,
                     dst_pixel.out_red);
            fail_count++;
          end
          if (want.out_green !== dst_pixel.out_green) begin
            $display("%0t: out_green expected %h got %h", $time, want.out_green,
                     dst_pixel.out_green);
            fail_count++;
          end
          if (want.out_blue !== dst_pixel.out_blue) begin
            $display("%0t: out_blue expected %h got %h", $time, want.out_blue,
                     dst_pixel.out_blue);
            fail_count++;
          end
          if (want.frame_last !== dst_pixel.frame_last) begin
            $display("%0t: frame_last expected %b got %b", $time, want.frame_last,
                     dst_pixel.frame_last);
            fail_count++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim/mipmap_downsample_filter_tb.sv =====
// Testbench top for the mipmap downsample filter: stimulus, stalls and verdict.
`default_nettype none
module mipmap_downsample_filter_tb;
  import mdf_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  src_valid;
  logic                  src_stall;
  pix_t                  src_pixel;
  logic                  dst_valid;
  logic                  dst_stall;
  out_pix_t              dst_pixel;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  // idle percentages for each side, changed by the stimulus as it goes
  int tx_idle_pct;
  int rx_idle_pct;
  // long receiver hold-off, requested by stimulus and counted by the receiver
  bit hold_req;
  int hold_left;
  int pixels_sent;

  mipmap_downsample_filter u_dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_pixel(src_pixel),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_pixel(dst_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mipmap_downsample_filter_checker u_checker (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_pixel(src_pixel),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_pixel(dst_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("mipmap_downsample_filter regression: fail");
    $finish;
  end

  // Receiver: random stall, or a long counted hold-off when one is requested.
  initial begin
    dst_stall <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        dst_stall <= 1'b1;
        hold_left--;
      end else begin
        dst_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Channel values biased toward the extremes.
  function automatic logic [7:0] chan_value();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    p.red = chan_value();
    p.green = chan_value();
    p.blue = chan_value();
    return p;
  endfunction

  // Send one source beat; values hold while stalled. src_stall is read at
  // the falling edge, where it is stable until the accepting edge.
  task automatic send_pixel(pix_t p);
    bit taken;
    // idle schedule follows how far the run has got
    if (pixels_sent < 333) begin
      tx_idle_pct = 25; rx_idle_pct = 62;
    end else if (pixels_sent < 666) begin
      tx_idle_pct = 62; rx_idle_pct = 25;
    end else begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_pixel <= p;
    do begin
      @(negedge clk);
      taken = !src_stall;
      @(posedge clk);
    end while (!taken);
    pixels_sent++;
  endtask

  // Drain every expected result, then give the pipe its latency to settle
  // so no item still in flight sees the register change.
  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(bit tent, int w, int h);
    drain();
    write_reg(CFG_FILTER_MODE, tent);
    write_reg(CFG_SRC_WIDTH, w);
    write_reg(CFG_SRC_HEIGHT, h);
  endtask

  task automatic send_fixed(logic [23:0] value, int count);
    for (int k = 0; k < count; k++) send_pixel(pix_t'(value));
  endtask

  initial begin
    int  w, h, n, total;
    bit  held, paused;
    rst = 1'b1;
    src_valid <= 1'b0;
    src_pixel <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FILTER_MODE;
    cfg_wdata <= '0;
    hold_req = 0;
    pixels_sent = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 62;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset geometry (2048 wide), a few extreme pixels, no result yet.
    send_fixed(24'hffffff, 2);
    send_fixed(24'h000000, 2);
    // Smallest frame, and dimension 0 / 1 both treated as 2: one pixel out
    // per four in, each one the frame's last.
    set_frame(1, 0, 1);
    send_fixed(24'hffffff, 4);
    send_fixed(24'h000000, 3);
    send_fixed(24'hffffff, 1);
    // odd dimensions drop the low bit
    set_frame(0, 3, 3);
    send_fixed(24'h80ff01, 4);
    // an unknown index is ignored and does not restart the frame
    send_fixed(24'h123456, 2);
    drain();
    write_reg(2'd3, 13'h1fff);
    send_fixed(24'h654321, 2);
    // widest / tallest register values; width saturates
    set_frame(1, 4095, 8191);
    send_fixed(24'hffffff, 3);
    set_frame(0, 4094, 4096);
    send_fixed(24'h000000, 3);

    // Random frames: mostly complete, small frames with random content,
    // some cut short and restarted by the next register write.
    held = 0;
    paused = 0;
    while (pixels_sent < 1000) begin
      w = ($urandom_range(3) != 0) ? 2 * $urandom_range(1, 10) : $urandom_range(2, 40);
      h = ($urandom_range(3) != 0) ? 2 * $urandom_range(1, 10) : $urandom_range(2, 30);
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(0, 1);
        h = $urandom_range(0, 1);
      end
      set_frame($urandom_range(1), w, h);
      total = (w < 2 ? 2 : w & ~1) * (h < 2 ? 2 : h & ~1);
      n = ($urandom_range(9) == 0) ? $urandom_range(1, total) : total;
      // the last frame is cut short at the item budget
      for (int k = 0; k < n && pixels_sent < 1000; k++) begin
        // once the sender stops until everything expected is out
        if (!paused && pixels_sent >= 500) begin
          paused = 1;
          src_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        // once the receiver holds off long enough to back up the input
        if (!held && pixels_sent >= 700) begin
          held = 1;
          hold_req = 1;
        end
        send_pixel(random_pixel());
      end
    end

    src_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("mipmap_downsample_filter regression: pass");
    else
      $display("mipmap_downsample_filter regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/mdf_pkg.sv
rtl/core/mdf_ram.sv
rtl/core/mdf_front.sv
rtl/core/mdf_queue.sv
rtl/core/mdf_back.sv
rtl/core/mipmap_downsample_filter.sv
sim/mipmap_downsample_filter_checker.sv
sim/mipmap_downsample_filter_tb.sv
